FILE: hw/rtl/ddo_pkg.sv
// ddo_pkg: shared types and constants for the differential drive odometry block
// payload structs, register indexes, sequencer states, cordic arctangent table
// no dependencies
package ddo_pkg;

	localparam int ANGLE_BITS    = 24;
	localparam int POSITION_BITS = 32;

	localparam int COUNT_W     = 32;
	localparam int DELTA_W     = COUNT_W + 1;
	localparam int DSUM_W      = DELTA_W + 1;
	localparam int ANGLE_STEP_W = 22;
	localparam int DISTANCE_W  = 16;
	localparam int MAX_DELTA_W = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 22;

	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA  = 2'd2;

	localparam logic [ANGLE_STEP_W-1:0] ANGLE_STEP_RESET = 22'd256319;
	localparam logic [DISTANCE_W-1:0]   DISTANCE_RESET   = 16'd128;
	localparam logic [MAX_DELTA_W-1:0]  MAX_DELTA_RESET  = 16'd40;

	localparam int CORDIC_W   = 34;
	localparam int TRIG_W     = 17;
	localparam int ATAN_LEN   = 24;
	localparam int ATAN_IDX_W = 5;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INIT = 34'sd652032874;

	localparam int TRAVEL_RAW_W = DSUM_W + DISTANCE_W + 1;
	localparam int TRAVEL_W     = 48;
	localparam int PROD_W       = TRAVEL_W + TRIG_W;
	localparam int INC_W        = PROD_W - 15;
	localparam int POS_SUM_W    = INC_W + 1;

	typedef struct packed {
		logic signed [COUNT_W-1:0] left_count;
		logic signed [COUNT_W-1:0] right_count;
		logic                      left_reverse;
		logic                      right_reverse;
	} ddo_in_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0]           heading;
		logic signed [POSITION_BITS-1:0] pos_x;
		logic signed [POSITION_BITS-1:0] pos_y;
		logic                            accepted;
	} ddo_out_t;

	typedef struct packed {
		logic start;
	} ddo_trig_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ddo_trig_sts_t;

	typedef enum logic [3:0] {
		ODO_IDLE,
		ODO_MUL,
		ODO_HDG,
		ODO_ROT_START,
		ODO_ROT_WAIT,
		ODO_MULX,
		ODO_MULY,
		ODO_ACCY,
		ODO_OUT
	} ddo_state_t;

	function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5339733;
			5'd8:  v = 32'd2669907;
			5'd9:  v = 32'd1334959;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/differential_drive_odometry.sv
// differential_drive_odometry: top level, dead reckoning of heading and position
// sequencer, delta check, heading and travel multipliers, saturating accumulators
// depends on ddo_pkg and ddo_cordic
//
// usage: one request on the in channel carries both wheel encoder counts and
// their reverse flags; each request gives exactly one result on the out channel
// with the updated heading, x and y position and the accepted flag.
// the configuration port writes angle step, distance per count and delta limit
// at any edge with cfg_we high; write only while no request is in flight.
// a request passes the multiply, heading, rotation, product and accumulate states
// to its result; the rotation runs one step per cycle in ddo_cordic.
// in_ready is high only while the sequencer is idle, so no new request is taken
// before the sequencer is done with the last. a finished result sits in an output register,
// so the next request is taken while it waits. if the receiver stalls longer
// the sequencer holds the next result until out_ready frees the register.
// reset: counts, deltas, heading and position clear to zero, the registers
// take their default values and no result is pending.
module differential_drive_odometry #(
	parameter int TRIG_STEPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ddo_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ddo_pkg::ddo_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ddo_pkg::ddo_out_t                 out_data
);
	import ddo_pkg::*;

	localparam logic signed [TRAVEL_RAW_W-1:0] TRAVEL_HI =
		(TRAVEL_RAW_W'(1) <<< (TRAVEL_W - 1)) - TRAVEL_RAW_W'(1);
	localparam logic signed [TRAVEL_RAW_W-1:0] TRAVEL_LO = -TRAVEL_HI;
	localparam logic signed [POS_SUM_W-1:0] POS_HI =
		(POS_SUM_W'(1) <<< (POSITION_BITS - 1)) - POS_SUM_W'(1);
	localparam logic signed [POS_SUM_W-1:0] POS_LO = -POS_HI - POS_SUM_W'(1);

	ddo_state_t state_q, state_d;

	logic [ANGLE_STEP_W-1:0] angle_step_q;
	logic [DISTANCE_W-1:0]   distance_q;
	logic [MAX_DELTA_W-1:0]  max_delta_q;

	logic signed [COUNT_W-1:0]       prev_left_q, prev_right_q;
	logic signed [DELTA_W-1:0]       left_delta_q, right_delta_q;
	logic                            accepted_q;
	logic [ANGLE_BITS-1:0]           heading_q;
	logic signed [POSITION_BITS-1:0] x_q, y_q;
	logic [ANGLE_BITS-1:0]           hprod_s1;
	logic signed [TRAVEL_RAW_W-1:0]  travel_raw_s1;
	logic signed [TRAVEL_W-1:0]      travel_q;
	logic signed [PROD_W-1:0]        prod_q;
	logic                            out_valid_q;
	ddo_out_t                        out_q;

	logic                               accept, delta_ok, out_load;
	logic signed [DELTA_W-1:0]          dl_raw, dr_raw, dl, dr, limit;
	logic signed [DSUM_W-1:0]           hdiff, tsum;
	logic [ANGLE_BITS+ANGLE_STEP_W-1:0] hmul;
	logic signed [TRAVEL_RAW_W-1:0]     tmul;
	logic signed [TRAVEL_W-1:0]         travel_clamped;
	logic signed [TRIG_W-1:0]           mul_b, cos15, sin15;
	logic signed [PROD_W-1:0]           prod, prod_bias;
	logic signed [INC_W-1:0]            inc;
	logic signed [POS_SUM_W-1:0]        x_sum, y_sum;
	ddo_trig_ctl_t                      trig_ctl;
	ddo_trig_sts_t                      trig_sts;

	function automatic logic signed [POSITION_BITS-1:0] sat_pos(
		input logic signed [POS_SUM_W-1:0] v
	);
		logic signed [POSITION_BITS-1:0] r;
		priority if (v > POS_HI) r = POS_HI[POSITION_BITS-1:0];
		else if (v < POS_LO)     r = POS_LO[POSITION_BITS-1:0];
		else                     r = v[POSITION_BITS-1:0];
		return r;
	endfunction

	ddo_cordic #(
		.TRIG_STEPS(TRIG_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (trig_ctl),
		.heading(heading_q),
		.sts    (trig_sts),
		.cos15  (cos15),
		.sin15  (sin15)
	);

	// delta check against the last accepted counts
	assign dl_raw   = {in_data.left_count[COUNT_W-1], in_data.left_count}
	                - {prev_left_q[COUNT_W-1], prev_left_q};
	assign dr_raw   = {in_data.right_count[COUNT_W-1], in_data.right_count}
	                - {prev_right_q[COUNT_W-1], prev_right_q};
	assign dl       = in_data.left_reverse ? -dl_raw : dl_raw;
	assign dr       = in_data.right_reverse ? -dr_raw : dr_raw;
	assign limit    = $signed({(DELTA_W - MAX_DELTA_W)'(0), max_delta_q});
	assign delta_ok = (dl < limit) && (dr < limit);
	assign accept   = in_valid && in_ready;

	assign hdiff = {left_delta_q[DELTA_W-1], left_delta_q}
	             - {right_delta_q[DELTA_W-1], right_delta_q};
	assign tsum  = {left_delta_q[DELTA_W-1], left_delta_q}
	             + {right_delta_q[DELTA_W-1], right_delta_q};
	assign hmul  = hdiff[ANGLE_BITS-1:0] * angle_step_q;
	assign tmul  = tsum * $signed({1'b0, distance_q});

	always_comb begin
		priority if (travel_raw_s1 > TRAVEL_HI) travel_clamped = TRAVEL_HI[TRAVEL_W-1:0];
		else if (travel_raw_s1 < TRAVEL_LO)     travel_clamped = TRAVEL_LO[TRAVEL_W-1:0];
		else                                    travel_clamped = travel_raw_s1[TRAVEL_W-1:0];
	end

	// shared multiplier: sin product first, then cos product
	assign mul_b     = (state_q == ODO_MULX) ? sin15 : cos15;
	assign prod      = travel_q * mul_b;
	assign prod_bias = prod_q + PROD_W'(16384);
	assign inc       = prod_bias[PROD_W-1:15];
	assign x_sum     = POS_SUM_W'(x_q) + POS_SUM_W'(inc);
	assign y_sum     = POS_SUM_W'(y_q) - POS_SUM_W'(inc);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ODO_IDLE:      if (in_valid) state_d = ODO_MUL;
			ODO_MUL:       state_d = ODO_HDG;
			ODO_HDG:       state_d = ODO_ROT_START;
			ODO_ROT_START: state_d = ODO_ROT_WAIT;
			ODO_ROT_WAIT:  if (trig_sts.done) state_d = ODO_MULX;
			ODO_MULX:      state_d = ODO_MULY;
			ODO_MULY:      state_d = ODO_ACCY;
			ODO_ACCY:      state_d = ODO_OUT;
			ODO_OUT:       if (!out_valid_q || out_ready) state_d = ODO_IDLE;
			default:       state_d = ODO_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == ODO_IDLE);
		trig_ctl.start = (state_q == ODO_ROT_START);
		out_load       = (state_q == ODO_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ODO_IDLE;
			out_valid_q   <= 1'b0;
			angle_step_q  <= ANGLE_STEP_RESET;
			distance_q    <= DISTANCE_RESET;
			max_delta_q   <= MAX_DELTA_RESET;
			prev_left_q   <= '0;
			prev_right_q  <= '0;
			left_delta_q  <= '0;
			right_delta_q <= '0;
			heading_q     <= '0;
			x_q           <= '0;
			y_q           <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ANGLE_STEP: angle_step_q <= cfg_data[ANGLE_STEP_W-1:0];
					CFG_DISTANCE:   distance_q   <= cfg_data[DISTANCE_W-1:0];
					CFG_MAX_DELTA:  max_delta_q  <= cfg_data[MAX_DELTA_W-1:0];
					default: ;
				endcase
			end
			if (accept && delta_ok) begin
				prev_left_q   <= in_data.left_count;
				prev_right_q  <= in_data.right_count;
				left_delta_q  <= dl;
				right_delta_q <= dr;
			end
			if (state_q == ODO_HDG) heading_q <= heading_q + hprod_s1;
			if (state_q == ODO_MULY) x_q <= sat_pos(x_sum);
			if (state_q == ODO_ACCY) y_q <= sat_pos(y_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) accepted_q <= delta_ok;
		if (state_q == ODO_MUL) begin
			hprod_s1      <= hmul[ANGLE_BITS-1:0];
			travel_raw_s1 <= tmul;
		end
		if (state_q == ODO_HDG) travel_q <= travel_clamped;
		if (state_q == ODO_MULX || state_q == ODO_MULY) prod_q <= prod;
		if (out_load) begin
			out_q.heading  <= heading_q;
			out_q.pos_x    <= x_q;
			out_q.pos_y    <= y_q;
			out_q.accepted <= accepted_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_prev_update: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && delta_ok) |=> prev_left_q == $past(in_data.left_count)
			&& prev_right_q == $past(in_data.right_count))
		else $error("accepted counts not stored");
	a_heading_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(heading_q) |-> $past(state_q) == ODO_HDG)
		else $error("heading changed outside its update step");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && out_q.heading == $past(heading_q))
		else $error("result register not loaded");
	a_trig_start: assert property (@(posedge clk) disable iff (!arst_n)
		trig_ctl.start |-> !trig_sts.busy)
		else $error("cordic started while busy");

endmodule

FILE: hw/rtl/ddo_cordic.sv
// ddo_cordic: iterative shift-add cordic giving cos and sin of a heading in q.15
// one rotation step per cycle on add/sub units reused for every step, then quadrant fix and rounding
// depends on ddo_pkg
module ddo_cordic #(
	parameter int TRIG_STEPS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ddo_pkg::ddo_trig_ctl_t             ctl,
	input  logic [ddo_pkg::ANGLE_BITS-1:0]     heading,
	output ddo_pkg::ddo_trig_sts_t             sts,
	output logic signed [ddo_pkg::TRIG_W-1:0]  cos15,
	output logic signed [ddo_pkg::TRIG_W-1:0]  sin15
);
	import ddo_pkg::*;

	localparam int IW = $clog2(TRIG_STEPS + 1);

	logic                       busy_q, done_q;
	logic [IW-1:0]              iter_q;
	logic [1:0]                 quad_q;
	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;

	logic [31:0]                angle, angle_bias, resid;
	logic [1:0]                 quad;
	logic signed [CORDIC_W-1:0] xs, ys, atan_v;
	logic signed [CORDIC_W-1:0] rot_c, rot_s, c_round, s_round;
	logic                       last_iter, load;

	assign angle      = 32'(heading) << (32 - ANGLE_BITS);
	assign angle_bias = angle + 32'h2000_0000;
	assign quad       = angle_bias[31:30];
	assign resid      = angle - {quad, 30'd0};

	assign xs     = x_q >>> iter_q;
	assign ys     = y_q >>> iter_q;
	assign atan_v = $signed({2'b00, atan_entry(ATAN_IDX_W'(iter_q))});

	assign last_iter = (iter_q == IW'(TRIG_STEPS));
	assign load      = ctl.start && !busy_q;

	always_comb begin
		unique case (quad_q)
			2'd0: begin
				rot_c = x_q;
				rot_s = y_q;
			end
			2'd1: begin
				rot_c = -y_q;
				rot_s = x_q;
			end
			2'd2: begin
				rot_c = -x_q;
				rot_s = -y_q;
			end
			default: begin
				rot_c = y_q;
				rot_s = -x_q;
			end
		endcase
	end

	assign c_round = (rot_c + 34'sd16384) >>> 15;
	assign s_round = (rot_s + 34'sd16384) >>> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (last_iter) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					iter_q <= iter_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quad_q <= quad;
			x_q    <= CORDIC_GAIN_INIT;
			y_q    <= '0;
			z_q    <= CORDIC_W'($signed(resid));
		end else if (busy_q && !last_iter) begin
			if (!z_q[CORDIC_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end
		end else if (busy_q) begin
			cos15 <= c_round[TRIG_W-1:0];
			sin15 <= s_round[TRIG_W-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && iter_q == '0)
		else $error("cordic did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("cordic done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("cordic done longer than one cycle");

endmodule
